>>> rtl/tvd_pkg.sv
package tvd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CRC_W    = 16;
   localparam int unsigned NUM_REGS = 6;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned DATA_W   = 32;

   localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
   localparam logic [BYTE_W-1:0] KEY_INIT = 8'hFF;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_MULT_A_EVEN = 3'd0;
   localparam logic [2:0] REG_MULT_A_ODD  = 3'd1;
   localparam logic [2:0] REG_MULT_B_EVEN = 3'd2;
   localparam logic [2:0] REG_MULT_B_ODD  = 3'd3;
   localparam logic [2:0] REG_MULT_C_EVEN = 3'd4;
   localparam logic [2:0] REG_MULT_C_ODD  = 3'd5;

   // Reset values of the key multipliers.
   localparam logic [BYTE_W-1:0] RST_MULT_A_EVEN = 8'd251;
   localparam logic [BYTE_W-1:0] RST_MULT_A_ODD  = 8'd223;
   localparam logic [BYTE_W-1:0] RST_MULT_B_EVEN = 8'd239;
   localparam logic [BYTE_W-1:0] RST_MULT_B_ODD  = 8'd139;
   localparam logic [BYTE_W-1:0] RST_MULT_C_EVEN = 8'd227;
   localparam logic [BYTE_W-1:0] RST_MULT_C_ODD  = 8'd151;

   // Control that the top level hands to each descrambler lane.
   typedef struct packed {
      logic              accept;
      logic              last;
      logic [BYTE_W-1:0] mult;
   } lane_ctl_type;

   // One result item as produced by the merging stage.
   typedef struct packed {
      logic [BYTE_W-1:0] voted_byte;
      logic              end_of_packet;
      logic              crc_good;
   } result_type;

   // Byte-wide CRC-16 update, most significant bit first.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/tvd_req_if.sv
interface tvd_req_if;
   logic                        valid;
   logic                        ready;
   logic [tvd_pkg::BYTE_W-1:0] copy_a_byte;
   logic [tvd_pkg::BYTE_W-1:0] copy_b_byte;
   logic [tvd_pkg::BYTE_W-1:0] copy_c_byte;
   logic                        last_byte;

   modport source (output valid, copy_a_byte, copy_b_byte, copy_c_byte, last_byte,
                   input ready);
   modport sink (input valid, copy_a_byte, copy_b_byte, copy_c_byte, last_byte,
                 output ready);
endinterface

>>> rtl/tvd_rsp_if.sv
interface tvd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tvd_pkg::BYTE_W-1:0] voted_byte;
   logic                        end_of_packet;
   logic                        crc_good;

   modport source (output valid, voted_byte, end_of_packet, crc_good, input ready);
   modport sink (input valid, voted_byte, end_of_packet, crc_good, output ready);
endinterface

>>> rtl/tvd_lane.sv
module tvd_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  tvd_pkg::lane_ctl_type       ctl,
   input  logic [tvd_pkg::BYTE_W-1:0] rx_byte,
   output logic [tvd_pkg::BYTE_W-1:0] plain_byte
);

   logic [tvd_pkg::BYTE_W-1:0]   key_ff;
   logic [tvd_pkg::BYTE_W-1:0]   key_in;
   logic [2*tvd_pkg::BYTE_W-1:0] product;

   // Advance the key stream, then strip it from the received byte.
   assign product    = key_ff * ctl.mult;
   assign plain_byte = rx_byte ^ product[tvd_pkg::BYTE_W-1:0];

   // Cipher feedback: the received byte seeds the next key.
   always_comb begin
      key_in = key_ff;
      if (ctl.accept) begin
         key_in = ctl.last ? tvd_pkg::KEY_INIT : (rx_byte | 8'h01);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= tvd_pkg::KEY_INIT;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

>>> rtl/tvd_merge.sv
module tvd_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        last,
   input  logic [tvd_pkg::BYTE_W-1:0] plain_a,
   input  logic [tvd_pkg::BYTE_W-1:0] plain_b,
   input  logic [tvd_pkg::BYTE_W-1:0] plain_c,
   output tvd_pkg::result_type         result
);

   logic [tvd_pkg::CRC_W-1:0]  crc_ff, crc_in, crc_upd;
   logic [tvd_pkg::BYTE_W-1:0] prev_ff, prev_in;
   logic [tvd_pkg::BYTE_W-1:0] prev2_ff, prev2_in;
   logic [1:0]                 seen_ff, seen_in;
   logic [tvd_pkg::BYTE_W-1:0] disagree;
   logic [tvd_pkg::BYTE_W-1:0] voted;

   // Bitwise vote: where A and B disagree the bit comes from C.
   assign disagree = plain_a ^ plain_b;
   assign voted    = (plain_a & ~disagree) | (disagree & plain_c);

   // The byte two back is known not to be part of the trailing pair.
   assign crc_upd = (seen_ff == 2'd2) ? tvd_pkg::crc_byte(crc_ff, prev2_ff) : crc_ff;

   assign result.voted_byte    = voted;
   assign result.end_of_packet = last;
   assign result.crc_good      = last && (seen_ff != 2'd0) && (crc_upd == {prev_ff, voted});

   // History and checksum state; everything clears after the last byte.
   always_comb begin
      crc_in   = crc_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (last) begin
            crc_in   = tvd_pkg::CRC_INIT;
            prev_in  = '0;
            prev2_in = '0;
            seen_in  = '0;
         end else begin
            crc_in   = crc_upd;
            prev_in  = voted;
            prev2_in = prev_ff;
            if (seen_ff != 2'd2) begin
               seen_in = seen_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= tvd_pkg::CRC_INIT;
         prev_ff  <= '0;
         prev2_ff <= '0;
         seen_ff  <= '0;
      end else begin
         crc_ff   <= crc_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

>>> rtl/triple_copy_vote_descrambler_core.sv
// Triple-copy vote descrambler.
// The req channel carries one scrambled byte from each of three copies of a
// packet plus a last-byte flag; the rsp channel returns one descrambled,
// bitwise voted byte for every request, with end_of_packet and, on the last
// byte, crc_good (CRC-16 of all but the trailing two bytes against them).
// Three descrambler lanes run side by side, one per copy, and a merging stage
// votes the lanes and keeps the CRC and byte history.
// Each result is registered and shown on rsp from the cycle after its
// request transfers. Throughput is one byte per cycle while rsp is ready;
// the single output register is refilled in the same cycle that its result
// is transferred. When the receiver stalls, the result holds and req.ready
// falls until it is taken. The key feedback (multiply, XOR) sets the cycle.
// Reset clears keys, phase, CRC and history and restores the key multipliers
// to their defaults; all packet state also clears after each last byte.
// The APB-style port at psel/penable/pwrite/paddr holds the six multipliers
// at byte addresses 0, 4, ... 20; write them only while the block is idle.
module triple_copy_vote_descrambler_core (
   input  logic                         clock,
   input  logic                         reset,
   tvd_req_if.sink                      req,
   tvd_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tvd_pkg::ADDR_W-1:0]  paddr,
   input  logic [tvd_pkg::DATA_W-1:0]  pwdata,
   output logic [tvd_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   logic [tvd_pkg::BYTE_W-1:0] mult_ff [tvd_pkg::NUM_REGS];
   logic [tvd_pkg::BYTE_W-1:0] mult_in [tvd_pkg::NUM_REGS];
   logic                        odd_ff, odd_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tvd_pkg::result_type         rsp_data_ff, rsp_data_in;
   logic                        accept;
   logic                        wr_en;
   logic [2:0]                  reg_idx;
   logic [tvd_pkg::BYTE_W-1:0] rd_byte;
   tvd_pkg::lane_ctl_type       ctl_a, ctl_b, ctl_c;
   logic [tvd_pkg::BYTE_W-1:0] plain_a, plain_b, plain_c;
   tvd_pkg::result_type         result;

   // A new request may enter whenever the output register frees up.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Configuration port.
   assign pready  = 1'b1;
   assign reg_idx = paddr[tvd_pkg::ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign prdata  = {{(tvd_pkg::DATA_W-tvd_pkg::BYTE_W){1'b0}}, rd_byte};

   always_comb begin
      unique case (reg_idx)
         tvd_pkg::REG_MULT_A_EVEN: rd_byte = mult_ff[tvd_pkg::REG_MULT_A_EVEN];
         tvd_pkg::REG_MULT_A_ODD:  rd_byte = mult_ff[tvd_pkg::REG_MULT_A_ODD];
         tvd_pkg::REG_MULT_B_EVEN: rd_byte = mult_ff[tvd_pkg::REG_MULT_B_EVEN];
         tvd_pkg::REG_MULT_B_ODD:  rd_byte = mult_ff[tvd_pkg::REG_MULT_B_ODD];
         tvd_pkg::REG_MULT_C_EVEN: rd_byte = mult_ff[tvd_pkg::REG_MULT_C_EVEN];
         tvd_pkg::REG_MULT_C_ODD:  rd_byte = mult_ff[tvd_pkg::REG_MULT_C_ODD];
         default:                  rd_byte = '0;
      endcase
   end

   // Register writes; indexes past the list are ignored.
   always_comb begin
      for (int i = 0; i < tvd_pkg::NUM_REGS; i++) begin
         mult_in[i] = mult_ff[i];
      end
      if (wr_en) begin
         unique case (reg_idx)
            tvd_pkg::REG_MULT_A_EVEN:
               mult_in[tvd_pkg::REG_MULT_A_EVEN] = pwdata[tvd_pkg::BYTE_W-1:0];
            tvd_pkg::REG_MULT_A_ODD:
               mult_in[tvd_pkg::REG_MULT_A_ODD] = pwdata[tvd_pkg::BYTE_W-1:0];
            tvd_pkg::REG_MULT_B_EVEN:
               mult_in[tvd_pkg::REG_MULT_B_EVEN] = pwdata[tvd_pkg::BYTE_W-1:0];
            tvd_pkg::REG_MULT_B_ODD:
               mult_in[tvd_pkg::REG_MULT_B_ODD] = pwdata[tvd_pkg::BYTE_W-1:0];
            tvd_pkg::REG_MULT_C_EVEN:
               mult_in[tvd_pkg::REG_MULT_C_EVEN] = pwdata[tvd_pkg::BYTE_W-1:0];
            tvd_pkg::REG_MULT_C_ODD:
               mult_in[tvd_pkg::REG_MULT_C_ODD] = pwdata[tvd_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Multiplier phase alternates per byte and restarts with each packet.
   assign odd_in = accept ? (req.last_byte ? 1'b0 : !odd_ff) : odd_ff;

   // Lane control: each copy gets its own multiplier for this phase.
   assign ctl_a = '{accept: accept, last: req.last_byte,
                    mult: odd_ff ? mult_ff[tvd_pkg::REG_MULT_A_ODD]
                                 : mult_ff[tvd_pkg::REG_MULT_A_EVEN]};
   assign ctl_b = '{accept: accept, last: req.last_byte,
                    mult: odd_ff ? mult_ff[tvd_pkg::REG_MULT_B_ODD]
                                 : mult_ff[tvd_pkg::REG_MULT_B_EVEN]};
   assign ctl_c = '{accept: accept, last: req.last_byte,
                    mult: odd_ff ? mult_ff[tvd_pkg::REG_MULT_C_ODD]
                                 : mult_ff[tvd_pkg::REG_MULT_C_EVEN]};

   tvd_lane u_lane_a (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_a),
      .rx_byte    (req.copy_a_byte),
      .plain_byte (plain_a)
   );

   tvd_lane u_lane_b (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_b),
      .rx_byte    (req.copy_b_byte),
      .plain_byte (plain_b)
   );

   tvd_lane u_lane_c (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_c),
      .rx_byte    (req.copy_c_byte),
      .plain_byte (plain_c)
   );

   tvd_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .last    (req.last_byte),
      .plain_a (plain_a),
      .plain_b (plain_b),
      .plain_c (plain_c),
      .result  (result)
   );

   // Output register: loads on each request transfer, empties on response transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.voted_byte    = rsp_data_ff.voted_byte;
   assign rsp.end_of_packet = rsp_data_ff.end_of_packet;
   assign rsp.crc_good      = rsp_data_ff.crc_good;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff[tvd_pkg::REG_MULT_A_EVEN] <= tvd_pkg::RST_MULT_A_EVEN;
         mult_ff[tvd_pkg::REG_MULT_A_ODD]  <= tvd_pkg::RST_MULT_A_ODD;
         mult_ff[tvd_pkg::REG_MULT_B_EVEN] <= tvd_pkg::RST_MULT_B_EVEN;
         mult_ff[tvd_pkg::REG_MULT_B_ODD]  <= tvd_pkg::RST_MULT_B_ODD;
         mult_ff[tvd_pkg::REG_MULT_C_EVEN] <= tvd_pkg::RST_MULT_C_EVEN;
         mult_ff[tvd_pkg::REG_MULT_C_ODD]  <= tvd_pkg::RST_MULT_C_ODD;
         odd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < tvd_pkg::NUM_REGS; i++) begin
            mult_ff[i] <= mult_in[i];
         end
         odd_ff       <= odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tvd_pkg::*;

   localparam int PHASE_ITEMS    = 105;
   localparam int NUM_PHASES     = 7;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   // How the multipliers are loaded at the start of a phase.
   typedef enum int {
      CFG_KEEP,
      CFG_ZERO,
      CFG_MAX,
      CFG_ONE,
      CFG_SPLIT,
      CFG_RANDOM
   } mult_plan_t;

   // One directed transfer; known rows carry a hand-written result.
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic       last;
      logic       known;
      result_type want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;
   logic recv_ready = 1'b0;

   tvd_req_if req_ch();
   tvd_rsp_if rsp_ch();

   assign rsp_ch.ready = recv_ready;

   triple_copy_vote_descrambler_core dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // Predictor copy of the multipliers and of the per-packet state.
   logic [7:0]  mult_q [NUM_REGS] = '{RST_MULT_A_EVEN, RST_MULT_A_ODD, RST_MULT_B_EVEN,
                                      RST_MULT_B_ODD, RST_MULT_C_EVEN, RST_MULT_C_ODD};
   logic [7:0]  key_q [3];
   logic        odd_q;
   logic [15:0] crc_q;
   logic [7:0]  hist1_q;
   logic [7:0]  hist2_q;
   int unsigned seen_q;

   result_type  expected_results [$];
   result_type  oldest_result;
   logic [7:0]  pkt_a [$];
   logic [7:0]  pkt_b [$];
   logic [7:0]  pkt_c [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int fail_count     = 0;
   int items_sent     = 0;
   int packets_sent   = 0;
   int settings_used  = 1;
   int crc_passes     = 0;

   mult_plan_t phase_plan [NUM_PHASES] = '{CFG_KEEP, CFG_MAX, CFG_RANDOM, CFG_ONE,
                                           CFG_SPLIT, CFG_RANDOM, CFG_RANDOM};
   int phase_send_pct [NUM_PHASES] = '{0, 78, 0, 10, 0, 78, 0};
   int phase_recv_pct [NUM_PHASES] = '{0, 0, 78, 10, 0, 0, 78};

   // Directed rows run with every multiplier at zero, so each key is zero
   // and the descrambled byte equals the received one.
   stim_row_t directed_rows [20] = '{
      // One-byte packets never pass the CRC.
      '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      // Two bytes: nothing is covered, so FF FF matches the initial value.
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0}},
      '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      // Voting: A and B agree, then disagree on every bit.
      '{8'h5A, 8'h5A, 8'hA5, 1'b0, 1'b1, '{8'h5A, 1'b0, 1'b0}},
      '{8'h00, 8'hFF, 8'hAA, 1'b1, 1'b1, '{8'hAA, 1'b1, 1'b0}},
      // Partial disagreement, with a predicted three-byte packet end.
      '{8'hF0, 8'hFF, 8'h00, 1'b0, 1'b1, '{8'hF0, 1'b0, 1'b0}},
      '{8'h0F, 8'h00, 8'hFF, 1'b0, 1'b1, '{8'h0F, 1'b0, 1'b0}},
      '{8'h12, 8'h34, 8'h12, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
      // The standard check string with its CRC, one copy damaged on most bytes.
      '{8'h31, 8'h31, 8'h31, 1'b0, 1'b1, '{8'h31, 1'b0, 1'b0}},
      '{8'h32, 8'h32, 8'hCD, 1'b0, 1'b1, '{8'h32, 1'b0, 1'b0}},
      '{8'h33, 8'hCC, 8'h33, 1'b0, 1'b1, '{8'h33, 1'b0, 1'b0}},
      '{8'hCB, 8'h34, 8'h34, 1'b0, 1'b1, '{8'h34, 1'b0, 1'b0}},
      '{8'h35, 8'h35, 8'h00, 1'b0, 1'b1, '{8'h35, 1'b0, 1'b0}},
      '{8'h36, 8'h00, 8'h36, 1'b0, 1'b1, '{8'h36, 1'b0, 1'b0}},
      '{8'h00, 8'h37, 8'h37, 1'b0, 1'b1, '{8'h37, 1'b0, 1'b0}},
      '{8'h38, 8'h38, 8'h38, 1'b0, 1'b1, '{8'h38, 1'b0, 1'b0}},
      '{8'h39, 8'h39, 8'hC6, 1'b0, 1'b1, '{8'h39, 1'b0, 1'b0}},
      '{8'h29, 8'h29, 8'h29, 1'b0, 1'b1, '{8'h29, 1'b0, 1'b0}},
      '{8'hB1, 8'h4E, 8'hB1, 1'b1, 1'b1, '{8'hB1, 1'b1, 1'b1}}
   };

   // CRC-16, polynomial 0x1021, one byte shifted in MSB first.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {data, 8'h00};
      repeat (8) acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
      return acc;
   endfunction

   function automatic void clear_packet_state();
      key_q   = '{KEY_INIT, KEY_INIT, KEY_INIT};
      odd_q   = 1'b0;
      crc_q   = CRC_INIT;
      hist1_q = 8'h00;
      hist2_q = 8'h00;
      seen_q  = 0;
   endfunction

   // Descramble one byte of each copy, vote, and track the packet CRC.
   function automatic result_type descramble_step(input logic [7:0] ra, rb, rc,
                                                  input logic last);
      logic [7:0]  rx [3];
      logic [7:0]  plain [3];
      logic [7:0]  key_prod;
      logic [7:0]  disagree;
      logic [15:0] tail;
      result_type  res;
      rx = '{ra, rb, rc};
      for (int c = 0; c < 3; c++) begin
         key_prod = key_q[c] * mult_q[REG_MULT_A_EVEN + 2 * c + int'(odd_q)];
         plain[c] = rx[c] ^ key_prod;
         key_q[c] = rx[c] | 8'h01;
      end
      odd_q = ~odd_q;
      disagree = plain[0] ^ plain[1];
      res.voted_byte = (plain[0] & ~disagree) | (disagree & plain[2]);
      res.end_of_packet = last;
      res.crc_good = 1'b0;
      if (seen_q >= 2) crc_q = crc16_update(crc_q, hist2_q);
      if (last) begin
         tail = {hist1_q, res.voted_byte};
         res.crc_good = (seen_q >= 1) && (crc_q == tail);
         clear_packet_state();
      end else begin
         hist2_q = hist1_q;
         hist1_q = res.voted_byte;
         if (seen_q < 2) seen_q++;
      end
      return res;
   endfunction

   // One APB transfer: setup cycle, access cycle, then psel and penable drop.
   task automatic csr_access(input logic wr, input logic [2:0] idx,
                             input logic [7:0] wdata, output logic [DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h000000, wdata};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      if (wr && idx < NUM_REGS) mult_q[idx] = wdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [DATA_W-1:0] rd;
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_access(1'b0, 3'(i), 8'h00, rd);
         if (rd !== {24'h000000, mult_q[i]}) begin
            $error("mult register %0d: expected %0h, actual %0h", i, mult_q[i], rd);
            fail_count++;
         end
      end
   endtask

   task automatic apply_plan(input mult_plan_t plan);
      logic [DATA_W-1:0] rd;
      logic [7:0] value;
      for (int i = 0; i < NUM_REGS; i++) begin
         case (plan)
            CFG_ZERO:  value = 8'h00;
            CFG_MAX:   value = 8'hFF;
            CFG_ONE:   value = 8'h01;
            CFG_SPLIT: value = (i % 2 == 1) ? 8'hFF : 8'h00;
            default:   value = 8'($urandom);
         endcase
         csr_access(1'b1, 3'(i), value, rd);
      end
      // Writes past the last register must leave every register alone.
      for (int i = NUM_REGS; i < 8; i++) csr_access(1'b1, 3'(i), 8'($urandom), rd);
      check_registers();
      settings_used++;
   endtask

   // Present one transfer on the request channel and log its expected result.
   task automatic send_byte(input logic [7:0] a, b, c, input logic last,
                            input logic known, input result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.copy_a_byte <= a;
      req_ch.copy_b_byte <= b;
      req_ch.copy_c_byte <= c;
      req_ch.last_byte   <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = descramble_step(a, b, c, last);
      expected_results.push_back(known ? want : predicted);
      items_sent++;
   endtask

   // Stop sending and wait for every outstanding result plus a short tail.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Build the three received copies of one packet. Most packets are
   // scrambled properly with a valid CRC and light single-copy damage;
   // some get matching damage on A and B, and some are pure noise.
   task automatic build_packet();
      int kind;
      int n_bytes;
      int hit_pos;
      logic [7:0]  plain [$];
      logic [7:0]  enc_key [3];
      logic [7:0]  tx [3];
      logic [7:0]  key_prod;
      logic [7:0]  data;
      logic [7:0]  mask;
      logic [15:0] crc;
      logic        odd;
      pkt_a.delete();
      pkt_b.delete();
      pkt_c.delete();
      kind = $urandom_range(99);
      if (kind >= 85) begin
         n_bytes = $urandom_range(1, 10);
         repeat (n_bytes) begin
            pkt_a.push_back(8'($urandom));
            pkt_b.push_back(8'($urandom));
            pkt_c.push_back(8'($urandom));
         end
         return;
      end
      n_bytes = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(6);
      crc = CRC_INIT;
      repeat (n_bytes) begin
         data = 8'($urandom);
         plain.push_back(data);
         crc = crc16_update(crc, data);
      end
      plain.push_back(crc[15:8]);
      plain.push_back(crc[7:0]);
      enc_key = '{KEY_INIT, KEY_INIT, KEY_INIT};
      odd = 1'b0;
      foreach (plain[i]) begin
         for (int c = 0; c < 3; c++) begin
            key_prod = enc_key[c] * mult_q[REG_MULT_A_EVEN + 2 * c + int'(odd)];
            tx[c] = plain[i] ^ key_prod;
            enc_key[c] = tx[c] | 8'h01;
         end
         odd = ~odd;
         if ($urandom_range(4) == 0) tx[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
         pkt_a.push_back(tx[0]);
         pkt_b.push_back(tx[1]);
         pkt_c.push_back(tx[2]);
      end
      if (kind >= 70) begin
         hit_pos = $urandom_range(pkt_a.size() - 1);
         mask = 8'($urandom_range(1, 255));
         pkt_a[hit_pos] ^= mask;
         pkt_b[hit_pos] ^= mask;
      end
   endtask

   task automatic run_phase(input int ph);
      int start;
      int packets_here;
      if (phase_plan[ph] != CFG_KEEP) apply_plan(phase_plan[ph]);
      send_idle_pct  = phase_send_pct[ph];
      recv_stall_pct = phase_recv_pct[ph];
      start = items_sent;
      packets_here = 0;
      while (items_sent - start < PHASE_ITEMS) begin
         build_packet();
         foreach (pkt_a[i]) begin
            send_byte(pkt_a[i], pkt_b[i], pkt_c[i], i == pkt_a.size() - 1, 1'b0, '0);
         end
         packets_sent++;
         packets_here++;
         // Let the pipeline run completely dry after the first packet of each phase.
         if (packets_here == 1) drain_results();
      end
      drain_results();
   endtask

   // Receiver: random backpressure at the current phase's rate.
   always @(posedge clock) begin
      recv_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each result transfer with the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && recv_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: voted_byte %0h", rsp_ch.voted_byte);
            fail_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_ch.voted_byte !== oldest_result.voted_byte) begin
               $error("voted_byte: expected %0h, actual %0h",
                      oldest_result.voted_byte, rsp_ch.voted_byte);
               fail_count++;
            end
            if (rsp_ch.end_of_packet !== oldest_result.end_of_packet) begin
               $error("end_of_packet: expected %0b, actual %0b",
                      oldest_result.end_of_packet, rsp_ch.end_of_packet);
               fail_count++;
            end
            if (rsp_ch.crc_good !== oldest_result.crc_good) begin
               $error("crc_good: expected %0b, actual %0b",
                      oldest_result.crc_good, rsp_ch.crc_good);
               fail_count++;
            end
            if (oldest_result.crc_good) crc_passes++;
         end
      end
   end

   // Count cycles without any transfer on either channel or the APB port.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && recv_ready) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Main sequence.
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.copy_a_byte = 8'h00;
      req_ch.copy_b_byte = 8'h00;
      req_ch.copy_c_byte = 8'h00;
      req_ch.last_byte   = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      clear_packet_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      check_registers();
      run_phase(0);

      apply_plan(CFG_ZERO);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (directed_rows[r]) begin
         send_byte(directed_rows[r].a, directed_rows[r].b, directed_rows[r].c,
                   directed_rows[r].last, directed_rows[r].known, directed_rows[r].want);
      end
      drain_results();

      for (int ph = 1; ph < NUM_PHASES; ph++) run_phase(ph);

      $display("Sent %0d bytes in %0d random packets plus a directed table, under %0d",
               items_sent, packets_sent, settings_used);
      $display("multiplier settings and four idling patterns; %0d packets passed the CRC.",
               crc_passes);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
